>>> design/dte_pkg.sv
// Shared constants, types and the arctangent table for the ZYX Euler angle block.
// No dependencies.
package dte_pkg;

  localparam int CORDIC_STAGES = 16;
  // The arctangent table has 32 entries, so a larger count acts as 32.
  localparam int CS_N = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  localparam int DATA_W = 16;
  localparam int ANG_W  = 16;
  localparam int CW     = 36;   // CORDIC x/y width, holds gain growth of Q.16 inputs
  localparam int ZW     = 32;   // angle accumulator, 2^31 = pi

  localparam int RT_W      = 31;          // square root width
  localparam int SQ_STAGES = RT_W;        // one root bit per stage
  localparam int SQ_LAT    = SQ_STAGES + 1;
  localparam int REM_W     = RT_W + 4;
  localparam int OPND_W    = 2 * RT_W;
  localparam int V_W       = 29;          // 1 - s^2 in Q.28

  localparam logic [ZW-1:0]       Z_PI      = 32'h8000_0000;
  localparam logic [ZW-1:0]       Z_HALF    = 32'h0000_8000;
  localparam logic signed [16:0]  S_MAX     = 17'sd16384;
  localparam logic signed [16:0]  S_MIN     = -17'sd16384;
  localparam logic [29:0]         ONE_Q28   = 30'd268435456;

  typedef struct packed {
    logic signed [DATA_W-1:0] s;
    logic signed [DATA_W-1:0] m11;
    logic signed [DATA_W-1:0] m12;
    logic signed [DATA_W-1:0] m23;
    logic signed [DATA_W-1:0] m33;
    logic                     clamped;
  } side_t;

  // atan(2^-i), 2^31 = pi
  function automatic logic [ZW-1:0] atan_lut(input int unsigned idx);
    logic [ZW-1:0] r;
    case (idx)
      0:  r = 32'h20000000;  1:  r = 32'h12E4051E;  2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;  4:  r = 32'h028B0D43;  5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;  7:  r = 32'h00517C55;  8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;  10: r = 32'h000A2F98;  11: r = 32'h000517CC;
      12: r = 32'h00028BE6;  13: r = 32'h000145F3;  14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;  16: r = 32'h000028BE;  17: r = 32'h0000145F;
      18: r = 32'h00000A30;  19: r = 32'h00000518;  20: r = 32'h0000028C;
      21: r = 32'h00000146;  22: r = 32'h000000A3;  23: r = 32'h00000051;
      24: r = 32'h00000029;  25: r = 32'h00000014;  26: r = 32'h0000000A;
      27: r = 32'h00000005;  28: r = 32'h00000003;  29: r = 32'h00000001;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

>>> design/dte_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Depends on dte_pkg.
module dte_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [dte_pkg::OPND_W-1:0] opnd,
  output logic                       out_valid,
  output logic [dte_pkg::RT_W-1:0]   root
);
  import dte_pkg::*;

  logic [OPND_W-1:0] ops  [0:SQ_STAGES];
  logic [REM_W-1:0]  rems [0:SQ_STAGES];
  logic [RT_W-1:0]   qs   [0:SQ_STAGES];
  logic              vs   [0:SQ_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else begin
      vs[0] <= in_valid;
    end
    ops[0]  <= opnd;
    rems[0] <= '0;
    qs[0]   <= '0;
  end

  genvar j;
  for (j = 0; j < SQ_STAGES; j++) begin : g_st
    localparam int K = SQ_STAGES - 1 - j;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    assign rem_sh = {rems[j][REM_W-3:0], ops[j][2*K+1 -: 2]};
    assign trial  = {2'b00, qs[j], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[j+1] <= 1'b0;
      end else begin
        vs[j+1] <= vs[j];
      end
      ops[j+1] <= ops[j];
      if (rem_sh >= trial) begin
        rems[j+1] <= rem_sh - trial;
        qs[j+1]   <= {qs[j][RT_W-2:0], 1'b1};
      end else begin
        rems[j+1] <= rem_sh;
        qs[j+1]   <= {qs[j][RT_W-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vs[SQ_STAGES];
  assign root      = qs[SQ_STAGES];

endmodule

>>> design/dte_cordic.sv
// Pipelined vectoring CORDIC: 16-bit binary angle of (x, y).
// Depends on dte_pkg.
module dte_cordic (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic signed [dte_pkg::CW-1:0] x,
  input  logic signed [dte_pkg::CW-1:0] y,
  output logic                         out_valid,
  output logic [dte_pkg::ANG_W-1:0]    angle
);
  import dte_pkg::*;

  logic signed [CW-1:0] xs [0:CS_N];
  logic signed [CW-1:0] ys [0:CS_N];
  logic [ZW-1:0]        zs [0:CS_N];
  logic                 zf [0:CS_N];
  logic                 vs [0:CS_N];
  logic [ZW-1:0]        zr;

  // Fold the left half plane over by pi.
  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else begin
      vs[0] <= in_valid;
    end
    zf[0] <= (x == '0) && (y == '0);
    if (x[CW-1]) begin
      xs[0] <= -x;
      ys[0] <= -y;
      zs[0] <= Z_PI;
    end else begin
      xs[0] <= x;
      ys[0] <= y;
      zs[0] <= '0;
    end
  end

  genvar i;
  for (i = 0; i < CS_N; i++) begin : g_st
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else begin
        vs[i+1] <= vs[i];
      end
      zf[i+1] <= zf[i];
      if (!ys[i][CW-1]) begin
        xs[i+1] <= xs[i] + dx;
        ys[i+1] <= ys[i] - dy;
        zs[i+1] <= zs[i] + atan_lut(i);
      end else begin
        xs[i+1] <= xs[i] - dx;
        ys[i+1] <= ys[i] + dy;
        zs[i+1] <= zs[i] - atan_lut(i);
      end
    end
  end

  assign zr = zs[CS_N] + Z_HALF;

  // Round to 16 bits; the zero vector gives angle 0.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vs[CS_N];
    end
    angle <= zf[CS_N] ? '0 : zr[ZW-1:ZW-ANG_W];
  end

endmodule

>>> design/dcm_to_euler_zyx.sv
// Top level: ZYX Euler angles from five rotation matrix entries.
// Depends on dte_pkg, dte_sqrt and dte_cordic.
//
// Usage:
//   Drive m11, m12, m13, m23, m33 (signed Q2.14) and raise start for one
//   cycle per item. busy stays low: an item is taken in every cycle that start is high.
//   Each item comes back on yaw_angle, pitch_angle, roll_angle and
//   pitch_clamped with done high for exactly one cycle.
// Path from start to done: one input stage, the 31-stage square root
//   for cos(pitch) and its input register, then the three CORDIC
//   pipelines side by side.
// Throughput: one item per cycle, set by the fully unrolled root and
//   CORDIC stages.
// Reset: rst clears all valid bits; items in flight are dropped.
// The receiver cannot stall: results are shown for one cycle only.
module dcm_to_euler_zyx (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [dte_pkg::DATA_W-1:0] m11,
  input  logic signed [dte_pkg::DATA_W-1:0] m12,
  input  logic signed [dte_pkg::DATA_W-1:0] m13,
  input  logic signed [dte_pkg::DATA_W-1:0] m23,
  input  logic signed [dte_pkg::DATA_W-1:0] m33,
  output logic                           done,
  output logic signed [dte_pkg::ANG_W-1:0] yaw_angle,
  output logic signed [dte_pkg::ANG_W-1:0] pitch_angle,
  output logic signed [dte_pkg::ANG_W-1:0] roll_angle,
  output logic                           pitch_clamped
);
  import dte_pkg::*;

  localparam int CD_LAT = CS_N + 2;
  localparam int LAT    = 1 + SQ_LAT + CD_LAT;

  logic              accept;
  logic signed [16:0] neg;
  logic signed [DATA_W-1:0] s_next;
  logic              clamp_next;
  logic [14:0]       abs_s;
  logic [29:0]       s2;

  side_t             side0;
  logic [V_W-1:0]    v0;
  logic              valid0;
  side_t             side_d [0:SQ_LAT-1];

  logic              sq_valid;
  logic [RT_W-1:0]   root;
  logic              clamp_d [0:CD_LAT-1];
  logic              yaw_v, pitch_v, roll_v;
  logic [ANG_W-1:0]  yaw_a, pitch_a, roll_a;
  side_t             sa;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Clamp the pitch sine to [-1, 1] and form 1 - s^2 in Q.28.
  always_comb begin
    neg        = -{m13[DATA_W-1], m13};
    clamp_next = 1'b0;
    s_next     = DATA_W'(neg);
    if (neg > S_MAX) begin
      s_next     = DATA_W'(S_MAX);
      clamp_next = 1'b1;
    end else if (neg < S_MIN) begin
      s_next     = DATA_W'(S_MIN);
      clamp_next = 1'b1;
    end
    abs_s = s_next[DATA_W-1] ? 15'(-s_next) : s_next[14:0];
    s2    = abs_s * abs_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
    end else begin
      valid0 <= accept;
    end
    side0.s       <= s_next;
    side0.m11     <= m11;
    side0.m12     <= m12;
    side0.m23     <= m23;
    side0.m33     <= m33;
    side0.clamped <= clamp_next;
    v0            <= V_W'(ONE_Q28 - s2);
  end

  dte_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid0),
    .opnd      ({1'b0, v0, 32'b0}),
    .out_valid (sq_valid),
    .root      (root)
  );

  // Hold the side data alongside the root pipeline.
  always_ff @(posedge clk) begin
    side_d[0] <= side0;
    for (int k = 1; k < SQ_LAT; k++) begin
      side_d[k] <= side_d[k-1];
    end
  end

  assign sa = side_d[SQ_LAT-1];

  always_ff @(posedge clk) begin
    clamp_d[0] <= sa.clamped;
    for (int k = 1; k < CD_LAT; k++) begin
      clamp_d[k] <= clamp_d[k-1];
    end
  end

  dte_cordic u_yaw (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .x         ({{(CW-32){sa.m11[DATA_W-1]}}, sa.m11, 16'b0}),
    .y         ({{(CW-32){sa.m12[DATA_W-1]}}, sa.m12, 16'b0}),
    .out_valid (yaw_v),
    .angle     (yaw_a)
  );

  dte_cordic u_pitch (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .x         ({{(CW-RT_W){1'b0}}, root}),
    .y         ({{(CW-32){sa.s[DATA_W-1]}}, sa.s, 16'b0}),
    .out_valid (pitch_v),
    .angle     (pitch_a)
  );

  dte_cordic u_roll (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .x         ({{(CW-32){sa.m33[DATA_W-1]}}, sa.m33, 16'b0}),
    .y         ({{(CW-32){sa.m23[DATA_W-1]}}, sa.m23, 16'b0}),
    .out_valid (roll_v),
    .angle     (roll_a)
  );

  assign done          = yaw_v;
  assign yaw_angle     = yaw_a;
  assign pitch_angle   = pitch_a;
  assign roll_angle    = roll_a;
  assign pitch_clamped = clamp_d[CD_LAT-1];

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (yaw_v == pitch_v) && (yaw_v == roll_v))
    else $error("angle lanes out of step");

  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result without a matching item");

endmodule

>>> bench/dcm_to_euler_zyx_tb.sv
// Testbench for dcm_to_euler_zyx: drives rotation matrix entries and checks the
// Euler angles against a bit-exact predictor held in a small scoreboard class.
// Depends on dte_pkg and the dcm_to_euler_zyx design files.
`timescale 1ns / 100ps

module dcm_to_euler_zyx_tb;
  import dte_pkg::*;

  typedef struct {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic               clamped;
  } angles_t;

  // atan(2^-i), 2^31 = pi
  localparam logic [31:0] ATAN_ROM [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};

  class angle_scoreboard;
    angles_t pending[$];
    int      errors = 0;

    function automatic logic [31:0] vector_angle(longint y, longint x);
      logic [31:0] z;
      longint      dx, dy;
      int          n;
      z = 0;
      n = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h8000_0000;
      end
      for (int i = 0; i < n; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + ATAN_ROM[i];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - ATAN_ROM[i];
        end
      end
      return z;
    endfunction

    function automatic logic [15:0] round16(logic [31:0] z);
      logic [31:0] t;
      t = z + 32'h8000;
      return t[31:16];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function void note_item(logic signed [15:0] a11, a12, a13, a23, a33);
      angles_t         e;
      longint          s, sq;
      longint unsigned s2, c;
      s = -longint'(a13);
      e.clamped = 0;
      if (s > 16384) begin
        s = 16384;
        e.clamped = 1;
      end else if (s < -16384) begin
        s = -16384;
        e.clamped = 1;
      end
      sq = s * 65536;
      s2 = (sq < 0) ? -sq : sq;
      s2 = s2 * s2;
      c = int_sqrt((64'd1 << 60) - s2);
      e.yaw   = round16(vector_angle(longint'(a12) * 65536, longint'(a11) * 65536));
      e.pitch = round16(vector_angle(sq, longint'(c)));
      e.roll  = round16(vector_angle(longint'(a23) * 65536, longint'(a33) * 65536));
      pending.push_back(e);
    endfunction

    function void check_result(logic signed [15:0] y, p, r, logic cl);
      angles_t e;
      if (pending.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (y !== e.yaw) begin
        $error("yaw_angle expected %0d actual %0d", e.yaw, y); errors++;
      end
      if (p !== e.pitch) begin
        $error("pitch_angle expected %0d actual %0d", e.pitch, p); errors++;
      end
      if (r !== e.roll) begin
        $error("roll_angle expected %0d actual %0d", e.roll, r); errors++;
      end
      if (cl !== e.clamped) begin
        $error("pitch_clamped expected %0b actual %0b", e.clamped, cl); errors++;
      end
    endfunction
  endclass

  localparam int LATENCY   = 1 + 32 + CORDIC_STAGES + 2;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 0, rst = 1, start = 0;
  logic signed [15:0] m11 = 0, m12 = 0, m13 = 0, m23 = 0, m33 = 0;
  logic busy, done, pitch_clamped;
  logic signed [15:0] yaw_angle, pitch_angle, roll_angle;

  angle_scoreboard sb = new();
  int idle_cycles = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  dcm_to_euler_zyx i_dut (.*);

  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result(yaw_angle, pitch_angle, roll_angle, pitch_clamped);
    if ((start && !busy) || done) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("dcm_to_euler_zyx_tb NOT OK");
      $finish;
    end
  end

  function automatic logic signed [15:0] pick_entry();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'(16384 - $urandom_range(0, 3));
      3: return -16'(16384 - $urandom_range(0, 3));
      4: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 32768)) - 16'sd16384;
    endcase
  endfunction

  // Hold the item until it is taken; start is left high.
  task automatic send_item(logic signed [15:0] a11, a12, a13, a23, a33);
    m11 <= a11; m12 <= a12; m13 <= a13; m23 <= a23; m33 <= a33;
    start <= 1;
    do @(posedge clk); while (busy);
    sb.note_item(a11, a12, a13, a23, a33);
  endtask

  task automatic pause_line(int n);
    start <= 0;
    repeat (n) @(posedge clk);
  endtask

  initial begin
    int burst;
    logic signed [15:0] c, s;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // zero vectors, axis extremes, clamp edges
    send_item(0, 0, 0, 0, 0);
    send_item(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_item(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_item(-16384, 0, 16384, -16384, 0);
    send_item(-16384, 1, -16384, -1, -16384);
    send_item(-16384, -1, 16385, 1, -16384);
    send_item(0, 16384, -16385, 16384, 0);
    send_item(0, -16384, 16383, -16384, 0);
    send_item(16384, 0, -16383, 0, 16384);
    send_item(11585, 11585, 11585, -11585, 11585);
    send_item(-11585, -11585, -11585, 11585, -11585);
    send_item(1, 0, 1, 0, -1);
    send_item(-1, 0, -1, 0, 1);
    pause_line(1);

    for (int n = 0; n < 1950; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++, n++) begin
        if ($urandom_range(0, 3) != 0) begin
          // plausible rotation-ish entries
          c = 16'($urandom_range(0, 32768)) - 16'sd16384;
          s = 16'($urandom_range(0, 32768)) - 16'sd16384;
          send_item(c, s, 16'($urandom_range(0, 32768)) - 16'sd16384, s, c);
        end else begin
          send_item(pick_entry(), pick_entry(), pick_entry(), pick_entry(), pick_entry());
        end
      end
      if (n > 900 && n < 950) begin
        start <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        pause_line($urandom_range(1, 70));
      end
    end
    start <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("dcm_to_euler_zyx_tb OK");
    else
      $display("dcm_to_euler_zyx_tb NOT OK");
    $finish;
  end

endmodule
